>>> rtl/cpf_pkg.sv
`default_nettype none

package cpf_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] MODE_HDR   = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_CKSUM = 2'd2;
  localparam logic [1:0] MODE_PAD   = 2'd3;

  localparam logic [2:0] HDR_STEP_LAST = 3'd6;

  localparam logic [7:0]  HDR_BYTE    = 8'hA0;
  localparam logic [7:0]  CK_BASE     = 8'hAA;
  localparam logic [7:0]  CK_DEFAULT  = 8'h88;
  localparam logic [7:0]  RAW_CMD     = 8'hFF;
  localparam logic [7:0]  PAD_BYTE    = 8'h00;
  localparam logic [15:0] LEN_OUTER   = 16'd4;
  localparam logic [15:0] LEN_INNER   = 16'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command_id;
    logic [15:0] payload_length;
    logic        seed_present;
    logic [7:0]  seed_value;
    logic [7:0]  data_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_last;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  cmd;
    logic [15:0] len4;
    logic [15:0] len1;
    logic [7:0]  hsum;
    logic [7:0]  data;
  } load_t;

endpackage

`default_nettype wire

>>> rtl/command_packet_framer.sv
`default_nettype none

// Command packet framer: frames commands into a byte stream padded to whole
// CHUNK_BYTES-byte chunks. One result byte leaves per cycle through a single
// emitter; a data item sends one byte and can follow back to back, a start
// item in command mode sends the seven header bytes, an end item sends the
// checksum and then padding bytes (up to CHUNK_BYTES-1), or in raw mode only
// the padding, and a raw-mode start or an unused kind is taken with no
// result. The next item is taken in the cycle the emitter sends the last
// byte of the current one; out_ready low holds the emitter and the input.

module command_packet_framer #(
  parameter int CHUNK_BYTES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire cpf_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      cpf_pkg::out_item_t out_data
);

  logic [7:0]     sum;
  logic           raw_mode;
  logic           seed_used;
  logic           length_nonzero;

  logic           accept;
  logic           load_valid;
  logic           load_ready;
  cpf_pkg::load_t load;
  logic [15:0]    len4;
  logic           is_raw_cmd;
  logic [7:0]     ck;

  assign in_ready    = load_ready;
  assign accept      = in_valid && in_ready;
  assign len4        = in_data.payload_length + cpf_pkg::LEN_OUTER;
  assign is_raw_cmd  = (in_data.command_id == cpf_pkg::RAW_CMD);
  assign ck          = (seed_used && length_nonzero) ? cpf_pkg::CK_BASE - sum
                                                     : cpf_pkg::CK_DEFAULT;

  always_comb begin
    load.cmd  = in_data.command_id;
    load.len4 = len4;
    load.len1 = in_data.payload_length + cpf_pkg::LEN_INNER;
    load.hsum = cpf_pkg::HDR_BYTE + len4[7:0] + len4[15:8];
    load.data = in_data.data_value;
    load.mode = cpf_pkg::MODE_DATA;
    load_valid = 1'b0;
    unique case (in_data.kind)
      cpf_pkg::KIND_START: begin
        load.mode  = cpf_pkg::MODE_HDR;
        load_valid = in_valid && !is_raw_cmd;
      end
      cpf_pkg::KIND_DATA: begin
        load.mode  = cpf_pkg::MODE_DATA;
        load_valid = in_valid;
      end
      cpf_pkg::KIND_END: begin
        load.mode  = raw_mode ? cpf_pkg::MODE_PAD : cpf_pkg::MODE_CKSUM;
        load.data  = ck;
        load_valid = in_valid;
      end
      default: begin
        load_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum            <= '0;
      raw_mode       <= 1'b0;
      seed_used      <= 1'b0;
      length_nonzero <= 1'b0;
    end else if (accept) begin
      if (in_data.kind == cpf_pkg::KIND_START) begin
        raw_mode       <= is_raw_cmd;
        seed_used      <= in_data.seed_present;
        length_nonzero <= (in_data.payload_length != '0);
        sum            <= in_data.seed_value;
      end else if (in_data.kind == cpf_pkg::KIND_DATA) begin
        sum <= sum + in_data.data_value;
      end
    end
  end

  cpf_emitter #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load_ready (load_ready),
    .load       (load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/cpf_emitter.sv
`default_nettype none

module cpf_emitter #(
  parameter int CHUNK_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load_valid,
  output      logic              load_ready,
  input  wire cpf_pkg::load_t    load,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      cpf_pkg::out_item_t out_data
);

  localparam int OFF_W = $clog2(CHUNK_BYTES);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(CHUNK_BYTES - 1);

  logic             busy;
  logic [1:0]       mode;
  logic [2:0]       step;
  cpf_pkg::load_t   cur;
  logic [OFF_W-1:0] offset;

  logic             slot_free;
  logic             skip;
  logic             fire;
  logic             wrap;
  logic             last_byte;
  logic             done;
  logic [7:0]       byte_sel;

  assign slot_free  = !out_valid || out_ready;
  assign skip       = busy && (mode == cpf_pkg::MODE_PAD) && (offset == '0);
  assign fire       = busy && slot_free && !skip;
  assign wrap       = (offset == OFF_LAST);
  assign done       = skip || (fire && last_byte);
  assign load_ready = !busy || done;

  always_comb begin
    byte_sel  = cpf_pkg::PAD_BYTE;
    last_byte = wrap;
    unique case (mode)
      cpf_pkg::MODE_HDR: begin
        last_byte = (step == cpf_pkg::HDR_STEP_LAST);
        unique case (step)
          3'd0:    byte_sel = cpf_pkg::HDR_BYTE;
          3'd1:    byte_sel = cur.len4[7:0];
          3'd2:    byte_sel = cur.len4[15:8];
          3'd3:    byte_sel = cur.hsum;
          3'd4:    byte_sel = cur.cmd;
          3'd5:    byte_sel = cur.len1[7:0];
          default: byte_sel = cur.len1[15:8];
        endcase
      end
      cpf_pkg::MODE_DATA: begin
        byte_sel  = cur.data;
        last_byte = 1'b1;
      end
      cpf_pkg::MODE_CKSUM: begin
        byte_sel = cur.data;
      end
      default: begin
        byte_sel = cpf_pkg::PAD_BYTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.out_byte   <= byte_sel;
      out_data.chunk_last <= wrap;
      out_data.run_last   <= last_byte;
    end
    if (load_valid && load_ready) begin
      cur <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mode      <= cpf_pkg::MODE_DATA;
      step      <= '0;
      offset    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        offset    <= wrap ? '0 : offset + OFF_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_valid && load_ready) begin
        busy <= 1'b1;
        mode <= load.mode;
        step <= '0;
      end else begin
        if (done) begin
          busy <= 1'b0;
        end else if (fire) begin
          if (mode == cpf_pkg::MODE_CKSUM) begin
            mode <= cpf_pkg::MODE_PAD;
          end
          step <= step + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire
